// ----- rtl/bfn_pkg.sv -----
// ----------------------------------------------------------------------------
// bfn_pkg
// Shared types and constants of the shortest-path engine with negative-cycle
// marking.
// ----------------------------------------------------------------------------
`default_nettype none

package bfn_pkg;

  localparam int unsigned DEF_MAX_NODES = 64;
  localparam int unsigned DEF_MAX_EDGES = 256;
  localparam int unsigned NODE_FW = 6;
  localparam int unsigned NC_W = 7;
  localparam int unsigned IN_DW = 56;
  localparam int unsigned OUT_DW = 72;

  localparam logic signed [63:0] DIST_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] DIST_MIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_RUN   = 2'd2,
    OP_READ  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_UNREACH = 2'd0,
    ST_CYCLE   = 2'd1,
    ST_FINITE  = 2'd2,
    ST_UNUSED  = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [31:0] weight;
    logic [5:0]         head;
    logic [5:0]         tail;
  } edge_t;

  typedef struct packed {
    logic               cyc;
    logic               reach;
    logic signed [63:0] distance;
  } node_t;

endpackage

`default_nettype wire

// ----- rtl/bellman_ford_negative_cycle_marking.sv -----
// ----------------------------------------------------------------------------
// bellman_ford_negative_cycle_marking
// Shortest paths over a stored edge list with negative-cycle marking.
// ----------------------------------------------------------------------------
// The input stream carries the opcode in tuser and the edge or node fields in
// tdata. Clear and add-edge items are done as they are taken, so the next item
// can follow at once. A read item produces one transfer on the output stream:
// the status in tuser, the distance and the overflow flag in tdata. A run item
// occupies the block: it first sweeps the node memory, one node a cycle, then,
// if the source is below node_count, makes node_count-1 relaxation passes, one
// detection pass and one or more marking passes over the edge list. Each pass
// starts with a setup state. Each edge goes through edge read, node read, add,
// and compare and write back; the add is skipped if an endpoint is not below
// node_count. The edge memory read, the node memory read and the sum ahead of
// the compare are each registered. While a run is in progress tready is low.
// A finished read result sits in an output register; while the receiver
// stalls, clear and add-edge items are still taken, and a following read
// waits until that register is free. Reset empties the edge list, sets
// node_count to min(MAX_NODES, 64) and makes every node read as unreachable.
// ----------------------------------------------------------------------------
`default_nettype none

module bellman_ford_negative_cycle_marking #(
  parameter int unsigned MAX_NODES = bfn_pkg::DEF_MAX_NODES,
  parameter int unsigned MAX_EDGES = bfn_pkg::DEF_MAX_EDGES
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bfn_pkg::NC_W-1:0]      cfg_wdata_i,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // edge_tail, edge_head, edge_weight, node_select
  input  wire logic [bfn_pkg::IN_DW-1:0]     s_axis_tdata,
  // opcode
  input  wire logic [1:0]                    s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // path_distance, edge_overflow
  output logic [bfn_pkg::OUT_DW-1:0]         m_axis_tdata,
  // node_status
  output logic [1:0]                         m_axis_tuser
);
  import bfn_pkg::*;

  localparam int unsigned NW = $clog2(MAX_NODES);
  localparam int unsigned EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned CW = $clog2(MAX_EDGES + 1);
  localparam int unsigned NC_RST = (MAX_NODES < 64) ? MAX_NODES : 64;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_CLEAR = 4'd2;
  localparam logic [3:0] S_INIT  = 4'd3;
  localparam logic [3:0] S_PASS  = 4'd4;
  localparam logic [3:0] S_EADDR = 4'd5;
  localparam logic [3:0] S_ENODE = 4'd6;
  localparam logic [3:0] S_EADD  = 4'd7;
  localparam logic [3:0] S_ECMP  = 4'd8;

  localparam logic [1:0] PH_RELAX  = 2'd0;
  localparam logic [1:0] PH_DETECT = 2'd1;
  localparam logic [1:0] PH_PROP   = 2'd2;

  logic [3:0]         state_q, state_d;
  logic [1:0]         phase_q, phase_d;
  logic [CW-1:0]      edges_q, edges_d;
  logic               ovf_q, ovf_d;
  logic [NC_W-1:0]    nc_q, nc_d;
  logic               run_done_q, run_done_d;
  logic [NODE_FW-1:0] src_q, src_d;
  logic [NODE_FW-1:0] sel_q, sel_d;
  logic [CW-1:0]      ecnt_q, ecnt_d;
  logic [NC_W-1:0]    rnd_q, rnd_d;
  logic               chg_q, chg_d;
  logic [NW-1:0]      clr_q, clr_d;
  logic signed [63:0] cand_q, cand_d;
  logic               out_vld_q, out_vld_d;
  logic [OUT_DW-1:0]  out_data_q, out_data_d;
  logic [1:0]         out_user_q, out_user_d;

  logic            e_we, e_re;
  logic [EW-1:0]   e_waddr;
  edge_t           e_wdata, e_rdata;
  logic            n_we, n_re_a, n_re_b;
  logic [NW-1:0]   n_waddr, n_raddr_a, n_raddr_b;
  node_t           n_wdata, n_rdata_a, n_rdata_b;

  logic [1:0]         in_op;
  logic [NODE_FW-1:0] in_sel;
  logic               in_acc;
  logic               out_free;
  logic               last_edge;
  logic               edge_ok;
  logic signed [64:0] sum;
  logic signed [63:0] sat_sum;
  logic               better;
  logic [1:0]         rd_status;
  logic [NC_W-1:0]    cfg_v;

  assign in_op  = s_axis_tuser;
  assign in_sel = s_axis_tdata[49:44];
  assign e_wdata.tail   = s_axis_tdata[5:0];
  assign e_wdata.head   = s_axis_tdata[11:6];
  assign e_wdata.weight = s_axis_tdata[43:12];

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign last_edge     = ((ecnt_q + CW'(1)) == edges_q);
  assign edge_ok       = ({1'b0, e_rdata.tail} < nc_q) && ({1'b0, e_rdata.head} < nc_q);

  assign sum = {n_rdata_a.distance[63], n_rdata_a.distance} +
               {{33{e_rdata.weight[31]}}, e_rdata.weight};
  always_comb begin
    if (sum[64] != sum[63]) begin
      sat_sum = sum[64] ? DIST_MIN : DIST_MAX;
    end else begin
      sat_sum = sum[63:0];
    end
  end
  assign better = !n_rdata_b.reach || (cand_q < n_rdata_b.distance);

  always_comb begin
    if (({1'b0, sel_q} < nc_q) && run_done_q && n_rdata_a.reach) begin
      rd_status = n_rdata_a.cyc ? ST_CYCLE : ST_FINITE;
    end else begin
      rd_status = ST_UNREACH;
    end
  end

  always_comb begin
    cfg_v = cfg_wdata_i;
    if (cfg_v == '0) begin
      cfg_v = NC_W'(1);
    end else if (32'(cfg_v) > MAX_NODES) begin
      cfg_v = NC_W'(MAX_NODES);
    end
  end

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    edges_d    = edges_q;
    ovf_d      = ovf_q;
    nc_d       = cfg_we_i ? cfg_v : nc_q;
    run_done_d = run_done_q;
    src_d      = src_q;
    sel_d      = sel_q;
    ecnt_d     = ecnt_q;
    rnd_d      = rnd_q;
    chg_d      = chg_q;
    clr_d      = clr_q;
    cand_d     = cand_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_data_d = out_data_q;
    out_user_d = out_user_q;
    e_we       = 1'b0;
    e_waddr    = edges_q[EW-1:0];
    e_re       = 1'b0;
    n_we       = 1'b0;
    n_waddr    = NW'(e_rdata.head);
    n_wdata    = n_rdata_b;
    n_re_a     = 1'b0;
    n_raddr_a  = NW'(e_rdata.tail);
    n_re_b     = 1'b0;
    n_raddr_b  = NW'(e_rdata.head);

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            OP_CLEAR: begin
              edges_d = '0;
              ovf_d   = 1'b0;
            end
            OP_ADD: begin
              if (edges_q < CW'(MAX_EDGES)) begin
                e_we    = 1'b1;
                edges_d = edges_q + CW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            OP_RUN: begin
              src_d      = in_sel;
              run_done_d = 1'b1;
              clr_d      = '0;
              state_d    = S_CLEAR;
            end
            default: begin
              sel_d     = in_sel;
              n_re_a    = 1'b1;
              n_raddr_a = NW'(in_sel);
              state_d   = S_READ;
            end
          endcase
        end
      end
      S_READ: begin
        n_re_a    = 1'b1;
        n_raddr_a = NW'(sel_q);
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_user_d = rd_status;
          out_data_d = {7'd0, ovf_q,
                        (rd_status == ST_FINITE) ? n_rdata_a.distance : 64'sd0};
          n_re_a     = 1'b0;
          state_d    = S_IDLE;
        end
      end
      S_CLEAR: begin
        n_we    = 1'b1;
        n_waddr = clr_q;
        n_wdata = '0;
        clr_d   = clr_q + NW'(1);
        if (clr_q == NW'(MAX_NODES - 1)) begin
          state_d = ({1'b0, src_q} < nc_q) ? S_INIT : S_IDLE;
        end
      end
      S_INIT: begin
        n_we          = 1'b1;
        n_waddr       = NW'(src_q);
        n_wdata       = '0;
        n_wdata.reach = 1'b1;
        phase_d       = PH_RELAX;
        rnd_d         = '0;
        state_d       = S_PASS;
      end
      S_PASS: begin
        ecnt_d = '0;
        chg_d  = 1'b0;
        if (edges_q == '0) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_EADDR;
          if ((phase_q == PH_RELAX) && ((rnd_q + NC_W'(1)) >= nc_q)) begin
            phase_d = PH_DETECT;
          end
        end
      end
      S_EADDR: begin
        e_re    = 1'b1;
        state_d = S_ENODE;
      end
      S_ENODE: begin
        if (edge_ok) begin
          n_re_a  = 1'b1;
          n_re_b  = 1'b1;
          state_d = S_EADD;
        end else begin
          state_d = S_ECMP;
        end
      end
      S_EADD: begin
        cand_d = sat_sum;
        if (phase_q == PH_PROP) begin
          if (n_rdata_a.cyc && !n_rdata_b.cyc) begin
            n_we        = 1'b1;
            n_wdata.cyc = 1'b1;
            chg_d       = 1'b1;
          end
          state_d = S_ECMP;
        end else if (n_rdata_a.reach) begin
          state_d = S_ECMP;
        end else begin
          state_d = S_ECMP;
          cand_d  = cand_q;
        end
      end
      S_ECMP: begin
        if (edge_ok && (phase_q != PH_PROP) && n_rdata_a.reach && better) begin
          n_we = 1'b1;
          if (phase_q == PH_RELAX) begin
            n_wdata.reach    = 1'b1;
            n_wdata.distance = cand_q;
          end else begin
            n_wdata.cyc = 1'b1;
          end
        end
        state_d = S_EADDR;
        ecnt_d  = ecnt_q + CW'(1);
        if (last_edge) begin
          state_d = S_PASS;
          unique case (phase_q)
            PH_RELAX:  rnd_d = rnd_q + NC_W'(1);
            PH_DETECT: phase_d = PH_PROP;
            default: begin
              if (!chg_d) begin
                state_d = S_IDLE;
              end
            end
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      phase_q    <= PH_RELAX;
      edges_q    <= '0;
      ovf_q      <= 1'b0;
      nc_q       <= NC_W'(NC_RST);
      run_done_q <= 1'b0;
      ecnt_q     <= '0;
      rnd_q      <= '0;
      chg_q      <= 1'b0;
      clr_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      edges_q    <= edges_d;
      ovf_q      <= ovf_d;
      nc_q       <= nc_d;
      run_done_q <= run_done_d;
      ecnt_q     <= ecnt_d;
      rnd_q      <= rnd_d;
      chg_q      <= chg_d;
      clr_q      <= clr_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q      <= src_d;
    sel_q      <= sel_d;
    cand_q     <= cand_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  bfn_edge_mem #(
    .DEPTH (MAX_EDGES),
    .AW    (EW)
  ) u_edge_mem (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .re_i    (e_re),
    .raddr_i (ecnt_q[EW-1:0]),
    .rdata_o (e_rdata)
  );

  bfn_node_mem #(
    .DEPTH (MAX_NODES),
    .AW    (NW)
  ) u_node_mem (
    .clk_i     (clk_i),
    .we_i      (n_we),
    .waddr_i   (n_waddr),
    .wdata_i   (n_wdata),
    .re_a_i    (n_re_a),
    .raddr_a_i (n_raddr_a),
    .rdata_a_o (n_rdata_a),
    .re_b_i    (n_re_b),
    .raddr_b_i (n_raddr_b),
    .rdata_b_o (n_rdata_b)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser));

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser != ST_UNUSED));

  a_edges_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edges_q <= CW'(MAX_EDGES));

  a_nc_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nc_q != '0) && (32'(nc_q) <= MAX_NODES));

endmodule

`default_nettype wire

// ----- rtl/bfn_edge_mem.sv -----
// ----------------------------------------------------------------------------
// bfn_edge_mem
// Edge list storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bfn_edge_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  bfn_pkg::edge_t     wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output bfn_pkg::edge_t     rdata_o
);
  import bfn_pkg::*;

  edge_t mem_q [DEPTH];
  edge_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/bfn_node_mem.sv -----
// ----------------------------------------------------------------------------
// bfn_node_mem
// Per-node distance and flag storage: one write port, two registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module bfn_node_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  bfn_pkg::node_t     wdata_i,
  input  wire logic          re_a_i,
  input  wire logic [AW-1:0] raddr_a_i,
  output bfn_pkg::node_t     rdata_a_o,
  input  wire logic          re_b_i,
  input  wire logic [AW-1:0] raddr_b_i,
  output bfn_pkg::node_t     rdata_b_o
);
  import bfn_pkg::*;

  node_t mem_q [DEPTH];
  node_t rdata_a_q;
  node_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_a_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire
